// File: src/assert_macros.svh
// assertion macros used by the rtl file quaternion_to_rotation_matrix_top
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: src/q2r_pkg.sv
// types and constants of the quaternion to rotation matrix block
// no dependencies
package q2r_pkg;
	localparam int COMP_W    = 16;
	localparam int OUT_W     = 16;
	localparam int FRAC_OUT  = 14;
	localparam int DIV_STEPS = FRAC_OUT + 2;
	localparam int LATENCY   = 4 + DIV_STEPS;
	localparam logic signed [OUT_W-1:0] ONE = OUT_W'(1 << FRAC_OUT);

	typedef struct packed {
		logic signed [COMP_W-1:0] quat_x;
		logic signed [COMP_W-1:0] quat_y;
		logic signed [COMP_W-1:0] quat_z;
		logic signed [COMP_W-1:0] quat_w;
	} quat_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] rot_r0_c0;
		logic signed [OUT_W-1:0] rot_r0_c1;
		logic signed [OUT_W-1:0] rot_r0_c2;
		logic signed [OUT_W-1:0] rot_r1_c0;
		logic signed [OUT_W-1:0] rot_r1_c1;
		logic signed [OUT_W-1:0] rot_r1_c2;
		logic signed [OUT_W-1:0] rot_r2_c0;
		logic signed [OUT_W-1:0] rot_r2_c1;
		logic signed [OUT_W-1:0] rot_r2_c2;
		logic                    zero_length;
	} rot_t;
endpackage

// File: src/quaternion_to_rotation_matrix_top.sv
// Quaternion in, normalised 3x3 rotation matrix out (Q1.14, rounded to nearest).
// A new item may be started on every clock: busy is never raised, and the
// result of each item is presented on rot with done high for one cycle; the
// receiver cannot stall it. Each item passes through the input, product and
// sum stages, then the 16-stage restoring divider (one quotient bit per
// stage, nine entries in parallel), then the output register.
// An all-zero quaternion gives the identity matrix with zero_length set.
// depends on q2r_pkg and assert_macros.svh
`include "assert_macros.svh"
module quaternion_to_rotation_matrix_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  q2r_pkg::quat_t quat,
	output logic          done,
	output q2r_pkg::rot_t  rot
);
	import q2r_pkg::*;

	localparam int PW = 2 * COMP_W;
	localparam int NW = PW + 2;
	localparam int SW = PW + 1;

	// stage 1: inputs
	logic                     vld_s1;
	logic signed [COMP_W-1:0] x_s1, y_s1, z_s1, w_s1;
	// stage 2: products
	logic                 vld_s2;
	logic signed [PW-1:0] xx_s2, yy_s2, zz_s2, ww_s2, xy_s2, xz_s2, yz_s2, wx_s2, wy_s2, wz_s2;
	// stage 3: numerators and length
	logic                 vld_s3;
	logic signed [NW-1:0] num_s3 [9];
	logic [SW-1:0]        len_s3;
	// divider stages
	logic                 dvld_s4 [DIV_STEPS];
	logic                 dzero_s4 [DIV_STEPS];
	logic [SW-1:0]        dden_s4 [DIV_STEPS];
	logic [NW-1:0]        drem_s4 [DIV_STEPS][9];
	logic [DIV_STEPS-1:0] dquo_s4 [DIV_STEPS][9];
	logic                 dneg_s4 [DIV_STEPS][9];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			x_s1 <= quat.quat_x;
			y_s1 <= quat.quat_y;
			z_s1 <= quat.quat_z;
			w_s1 <= quat.quat_w;
		end
		xx_s2 <= x_s1 * x_s1;
		yy_s2 <= y_s1 * y_s1;
		zz_s2 <= z_s1 * z_s1;
		ww_s2 <= w_s1 * w_s1;
		xy_s2 <= x_s1 * y_s1;
		xz_s2 <= x_s1 * z_s1;
		yz_s2 <= y_s1 * z_s1;
		wx_s2 <= w_s1 * x_s1;
		wy_s2 <= w_s1 * y_s1;
		wz_s2 <= w_s1 * z_s1;
	end

	logic signed [NW-1:0] exx, eyy, ezz, eww, exy, exz, eyz, ewx, ewy, ewz;
	always_comb begin
		exx = NW'(xx_s2);
		eyy = NW'(yy_s2);
		ezz = NW'(zz_s2);
		eww = NW'(ww_s2);
		exy = NW'(xy_s2);
		exz = NW'(xz_s2);
		eyz = NW'(yz_s2);
		ewx = NW'(wx_s2);
		ewy = NW'(wy_s2);
		ewz = NW'(wz_s2);
	end

	always_ff @(posedge clk) begin
		num_s3[0] <= exx + eww - eyy - ezz;
		num_s3[1] <= (exy - ewz) <<< 1;
		num_s3[2] <= (exz + ewy) <<< 1;
		num_s3[3] <= (exy + ewz) <<< 1;
		num_s3[4] <= eyy + eww - exx - ezz;
		num_s3[5] <= (eyz - ewx) <<< 1;
		num_s3[6] <= (exz - ewy) <<< 1;
		num_s3[7] <= (eyz + ewx) <<< 1;
		num_s3[8] <= ezz + eww - exx - eyy;
		// squares are non-negative, so the sum fits unsigned
		len_s3 <= SW'(exx + eyy + ezz + eww);
	end

	// restoring division, one quotient bit per stage
	genvar k, e;
	generate
		for (k = 0; k < DIV_STEPS; k++) begin : g_step
			logic          vin;
			logic          zin;
			logic [SW-1:0] din;
			if (k == 0) begin : g_first
				assign vin = vld_s3;
				assign zin = (len_s3 == '0);
				assign din = len_s3;
			end else begin : g_next
				assign vin = dvld_s4[k-1];
				assign zin = dzero_s4[k-1];
				assign din = dden_s4[k-1];
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dvld_s4[k] <= 1'b0;
				end else begin
					dvld_s4[k] <= vin;
				end
			end

			always_ff @(posedge clk) begin
				dzero_s4[k] <= zin;
				dden_s4[k]  <= din;
			end

			for (e = 0; e < 9; e++) begin : g_ent
				logic [NW-1:0]        rin;
				logic [DIV_STEPS-1:0] qin;
				logic                 nin;
				logic                 ge;
				if (k == 0) begin : g_first
					assign nin = num_s3[e][NW-1];
					assign rin = nin ? NW'(-num_s3[e]) : NW'(num_s3[e]);
					assign qin = '0;
				end else begin : g_next
					assign nin = dneg_s4[k-1][e];
					assign rin = {drem_s4[k-1][e][NW-2:0], 1'b0};
					assign qin = dquo_s4[k-1][e];
				end
				assign ge = rin >= {1'b0, din};

				always_ff @(posedge clk) begin
					dneg_s4[k][e] <= nin;
					drem_s4[k][e] <= ge ? rin - {1'b0, din} : rin;
					dquo_s4[k][e] <= {qin[DIV_STEPS-2:0], ge};
				end
			end
		end
	endgenerate

	// rounding, sign and the zero-length case
	logic signed [OUT_W-1:0] ent [9];
	logic [DIV_STEPS:0]      rnd [9];
	always_comb begin
		for (int i = 0; i < 9; i++) begin
			rnd[i] = {1'b0, dquo_s4[DIV_STEPS-1][i]} + (DIV_STEPS+1)'(1);
			ent[i] = dneg_s4[DIV_STEPS-1][i] ? -OUT_W'(rnd[i][DIV_STEPS:1])
			                                 : OUT_W'(rnd[i][DIV_STEPS:1]);
			if (dzero_s4[DIV_STEPS-1]) begin
				ent[i] = (i == 0 || i == 4 || i == 8) ? ONE : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dvld_s4[DIV_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		rot.rot_r0_c0   <= ent[0];
		rot.rot_r0_c1   <= ent[1];
		rot.rot_r0_c2   <= ent[2];
		rot.rot_r1_c0   <= ent[3];
		rot.rot_r1_c1   <= ent[4];
		rot.rot_r1_c2   <= ent[5];
		rot.rot_r2_c0   <= ent[6];
		rot.rot_r2_c1   <= ent[7];
		rot.rot_r2_c2   <= ent[8];
		rot.zero_length <= dzero_s4[DIV_STEPS-1];
	end

	`ASSERT_RST(a_latency, clk, arst_n, start |-> ##LATENCY done, "item result missing at fixed latency")
	`ASSERT_RST(a_identity, clk, arst_n, done && rot.zero_length |-> rot.rot_r0_c0 == ONE && rot.rot_r1_c1 == ONE && rot.rot_r2_c2 == ONE && rot.rot_r0_c1 == '0, "zero length item not identity")
	`ASSERT_RST(a_range, clk, arst_n, done |-> rot.rot_r0_c0 <= ONE && rot.rot_r0_c0 >= -ONE && rot.rot_r1_c2 <= ONE && rot.rot_r1_c2 >= -ONE, "matrix entry out of range")
	`ASSERT_ALWAYS(a_never_busy, clk, !busy, "busy raised")
endmodule

// File: test/tb.sv
// testbench of quaternion_to_rotation_matrix_top: random and corner quaternions
// checked against an exact integer model of the normalised rotation matrix
// depends on q2r_pkg and the rtl of the block
`timescale 1ns / 100ps
module tb;
	import q2r_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	quat_t quat = '0;
	rot_t rot;

	quat_t pending_quats[$];
	rot_t matrices_due[$];
	int errors = 0;
	int items_sent = 0;
	int matrices_seen = 0;
	int idle_left = 0;
	int quiet_cycles = 0;
	bit calm_tail = 1'b0;
	bit stimulus_done = 1'b0;

	localparam int WATCHDOG = 2000;
	// items left when idling stops for the back to back tail
	localparam int TAIL_ITEMS = 60;

	quaternion_to_rotation_matrix_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.quat(quat), .done(done), .rot(rot)
	);

	always #4 clk = ~clk;

	// round(num * 2^14 / s), ties away from zero
	function automatic logic signed [OUT_W-1:0] entry_ratio(longint num, longint s);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = ((mag << (FRAC_OUT + 1)) / s + 1) >>> 1;
		return OUT_W'((num < 0) ? -q : q);
	endfunction

	function automatic rot_t rotation_of(quat_t q);
		rot_t r;
		longint x, y, z, w, s;
		x = q.quat_x; y = q.quat_y; z = q.quat_z; w = q.quat_w;
		s = x*x + y*y + z*z + w*w;
		r = '0;
		if (s == 0) begin
			r.rot_r0_c0 = ONE;
			r.rot_r1_c1 = ONE;
			r.rot_r2_c2 = ONE;
			r.zero_length = 1'b1;
			return r;
		end
		r.rot_r0_c0 = entry_ratio(x*x + w*w - y*y - z*z, s);
		r.rot_r0_c1 = entry_ratio(2*(x*y - w*z), s);
		r.rot_r0_c2 = entry_ratio(2*(x*z + w*y), s);
		r.rot_r1_c0 = entry_ratio(2*(x*y + w*z), s);
		r.rot_r1_c1 = entry_ratio(y*y + w*w - x*x - z*z, s);
		r.rot_r1_c2 = entry_ratio(2*(y*z - w*x), s);
		r.rot_r2_c0 = entry_ratio(2*(x*z - w*y), s);
		r.rot_r2_c1 = entry_ratio(2*(y*z + w*x), s);
		r.rot_r2_c2 = entry_ratio(z*z + w*w - x*x - y*y, s);
		return r;
	endfunction

	function automatic logic [COMP_W-1:0] random_component(int kind);
		case (kind)
			0: return COMP_W'($urandom);
			1: return COMP_W'($urandom_range(0, 7)) - COMP_W'(3);
			2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
			default: return COMP_W'($signed(COMP_W'($urandom)) >>> $urandom_range(0, 12));
		endcase
	endfunction

	task automatic add_quat(logic [COMP_W-1:0] x, y, z, w);
		quat_t q;
		q.quat_x = x; q.quat_y = y; q.quat_z = z; q.quat_w = w;
		pending_quats.push_back(q);
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				matrices_due.push_back(rotation_of(quat));
				items_sent++;
			end
			if (stimulus_done && pending_quats.size() <= TAIL_ITEMS) calm_tail <= 1'b1;
			if (!(start && busy)) begin
				if (!calm_tail && idle_left > 0) begin
					idle_left--;
					start <= 1'b0;
				end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
					idle_left = $urandom_range(1, 10) - 1;
					start <= 1'b0;
				end else if (pending_quats.size() > 0) begin
					quat <= pending_quats.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		rot_t want;
		if (arst_n && done) begin
			matrices_seen++;
			if (matrices_due.size() == 0) begin
				$display("%0t: matrix with none expected, actual %h", $time, rot);
				errors++;
			end else begin
				want = matrices_due.pop_front();
				if (rot !== want) begin
					$display("%0t: mismatch, expected %h actual %h", $time, want, rot);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int k;
		add_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		add_quat(16'h0000, 16'h0000, 16'h0000, 16'h4000);
		add_quat(16'h4000, 16'h0000, 16'h0000, 16'h0000);
		add_quat(16'h0000, 16'h4000, 16'h0000, 16'h0000);
		add_quat(16'h0000, 16'h0000, 16'h4000, 16'h0000);
		add_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		add_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		add_quat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
		add_quat(16'h0001, 16'h0000, 16'h0000, 16'h0000);
		add_quat(16'hffff, 16'h0001, 16'hffff, 16'h0001);
		add_quat(16'h0000, 16'h0000, 16'h0000, 16'h8000);
		add_quat(16'h2d41, 16'h0000, 16'h0000, 16'h2d41);
		add_quat(16'h0001, 16'h0001, 16'h0000, 16'h0000);
		add_quat(16'h0001, 16'h0001, 16'h0001, 16'h0000);
		add_quat(16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
		for (k = 0; k < 500; k++)
			add_quat(random_component($urandom_range(0, 3)),
				random_component($urandom_range(0, 3)),
				random_component($urandom_range(0, 3)),
				random_component($urandom_range(0, 3)));
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		stimulus_done = 1'b1;
		wait (pending_quats.size() == 0 && calm_tail);
		wait (matrices_due.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		$display("%0d quaternions driven, %0d matrices checked", items_sent, matrices_seen);
		$display("covered zero, axis, most negative and random components");
		if (errors == 0 && matrices_due.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
